// ===== src/tun_pkg.sv =====
`default_nettype none
package tun_pkg;

    // field widths
    localparam int COORD_WIDTH  = 16;
    localparam int NORMAL_WIDTH = 16;

    // derived widths
    localparam int EW    = COORD_WIDTH + 1;           // edge
    localparam int PW    = 2 * EW;                    // edge product
    localparam int CW    = PW + 1;                    // signed cross component
    localparam int MW    = PW;                        // cross magnitude
    localparam int SQW   = 2 * MW;                    // squared magnitude
    localparam int L2W   = SQW + 2;                   // squared length
    localparam int MBITS = NORMAL_WIDTH + 1;          // root digits, m <= 2*scale
    localparam int RW    = SQW + 2 * NORMAL_WIDTH;    // (2*|c|*scale)^2
    localparam int AW    = L2W + 2 * MBITS + 2;       // accumulator width
    localparam int NLANE = 3;

    localparam int IN_W  = 9 * COORD_WIDTH;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 3 * NORMAL_WIDTH;
    localparam int OUT_TW = ((OUT_W + 7) / 8) * 8;

    localparam logic [NORMAL_WIDTH-2:0] MAG_MAX = '1;

    // one lane of the digit recurrence
    typedef struct packed {
        logic [RW-1:0]    r;     // bound
        logic [AW-1:0]    p;     // t^2 * len2
        logic [AW-1:0]    qs;    // 2 * t * len2 * 2^k
        logic [MBITS-1:0] t;     // digits so far
        logic             neg;
    } lane_t;

    typedef struct packed {
        logic                 valid;
        logic                 deg;
        logic [AW-1:0]        d;     // len2 * 4^k
        lane_t [NLANE-1:0]    lane;
    } iter_t;

endpackage
`default_nettype wire

// ===== src/tun_root_step.sv =====
`default_nettype none
// One digit of the reciprocal-length recurrence for all three lanes.
module tun_root_step
    import tun_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  iter_t      in_i,
    output iter_t      out_o
);

    iter_t out_next;
    iter_t out_reg;

    // try setting the current digit in each lane
    always_comb begin
        logic [AW-1:0] trial;
        logic          ok;
        logic [AW-1:0] qsum;
        out_next = in_i;
        out_next.d = in_i.d >> 2;
        for (int i = 0; i < NLANE; i++) begin
            trial = in_i.lane[i].p + in_i.lane[i].qs + in_i.d;
            ok    = (trial <= {{(AW-RW){1'b0}}, in_i.lane[i].r});
            qsum  = ok ? (in_i.lane[i].qs + (in_i.d << 1)) : in_i.lane[i].qs;
            out_next.lane[i].p  = ok ? trial : in_i.lane[i].p;
            out_next.lane[i].qs = qsum >> 1;
            out_next.lane[i].t  = {in_i.lane[i].t[MBITS-2:0], ok};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg.valid <= out_next.valid;
        end
        if (en) begin
            out_reg.deg  <= out_next.deg;
            out_reg.d    <= out_next.d;
            out_reg.lane <= out_next.lane;
        end
    end

    assign out_o = out_reg;

endmodule
`default_nettype wire

// ===== src/triangle_unit_normal.sv =====
// Pipeline from input accept to result: 5 arithmetic stages, 17 root digit
// stages, 1 output register.
// Throughput: one item per cycle; the whole pipeline advances together and
// holds while a result waits on m_tready.
// Reset: aresetn clears the valid bits of every stage; data registers keep junk.
`default_nettype none
module triangle_unit_normal
    import tun_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    input  wire logic [IN_TW-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // norm_x, norm_y, norm_z
    output logic [OUT_TW-1:0]      m_tdata,
    // degenerate
    output logic                   m_tuser
);

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // stage 1: edges
    logic                 v1_reg;
    logic signed [EW-1:0] e_reg [6];   // e1x e1y e1z e2x e2y e2z
    logic signed [EW-1:0] e_next [6];

    always_comb begin
        logic signed [COORD_WIDTH-1:0] c0;
        logic signed [COORD_WIDTH-1:0] cn;
        for (int i = 0; i < 6; i++) begin
            c0 = $signed(s_tdata[(i % 3) * COORD_WIDTH +: COORD_WIDTH]);
            cn = $signed(s_tdata[(i + 3) * COORD_WIDTH +: COORD_WIDTH]);
            e_next[i] = EW'(cn) - EW'(c0);
        end
    end

    // stage 2: edge products
    logic                 v2_reg;
    logic signed [PW-1:0] pr_reg [6];
    logic signed [PW-1:0] pr_next [6];

    always_comb begin
        pr_next[0] = e_reg[1] * e_reg[5];   // ay*bz
        pr_next[1] = e_reg[2] * e_reg[4];   // az*by
        pr_next[2] = e_reg[2] * e_reg[3];   // az*bx
        pr_next[3] = e_reg[0] * e_reg[5];   // ax*bz
        pr_next[4] = e_reg[0] * e_reg[4];   // ax*by
        pr_next[5] = e_reg[1] * e_reg[3];   // ay*bx
    end

    // stage 3: cross product, split into sign and magnitude
    logic          v3_reg;
    logic [MW-1:0] mag_reg [NLANE];
    logic [MW-1:0] mag_next [NLANE];
    logic          neg_reg [NLANE];
    logic          neg_next [NLANE];
    logic          deg3_reg;
    logic          deg3_next;

    always_comb begin
        logic signed [CW-1:0] c;
        logic [CW-1:0]        a;
        deg3_next = 1'b1;
        for (int i = 0; i < NLANE; i++) begin
            c = CW'(pr_reg[2*i]) - CW'(pr_reg[2*i+1]);
            a = c[CW-1] ? -c : c;
            neg_next[i] = c[CW-1];
            mag_next[i] = a[MW-1:0];
            if (c != '0) begin
                deg3_next = 1'b0;
            end
        end
    end

    // stage 4: squares
    logic           v4_reg;
    logic [SQW-1:0] sq_reg [NLANE];
    logic           neg4_reg [NLANE];
    logic           deg4_reg;

    // stage 5: squared length and recurrence start
    iter_t it_next;
    iter_t it_reg;

    always_comb begin
        logic [L2W-1:0] len2;
        len2 = L2W'(sq_reg[0]) + L2W'(sq_reg[1]) + L2W'(sq_reg[2]);
        it_next.valid = v4_reg;
        it_next.deg   = deg4_reg;
        it_next.d     = AW'(len2) << (2 * (MBITS - 1));
        for (int i = 0; i < NLANE; i++) begin
            it_next.lane[i].r   = RW'(sq_reg[i]) << (2 * NORMAL_WIDTH);
            it_next.lane[i].p   = '0;
            it_next.lane[i].qs  = '0;
            it_next.lane[i].t   = '0;
            it_next.lane[i].neg = neg4_reg[i];
        end
    end

    // valid bits and data registers of the front stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            it_reg.valid <= 1'b0;
        end else if (en) begin
            v1_reg       <= s_tvalid;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
            it_reg.valid <= it_next.valid;
        end
        if (en) begin
            e_reg    <= e_next;
            pr_reg   <= pr_next;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            deg3_reg <= deg3_next;
            for (int i = 0; i < NLANE; i++) begin
                sq_reg[i] <= mag_reg[i] * mag_reg[i];
            end
            neg4_reg    <= neg_reg;
            deg4_reg    <= deg3_reg;
            it_reg.deg  <= it_next.deg;
            it_reg.d    <= it_next.d;
            it_reg.lane <= it_next.lane;
        end
    end

    // root digit chain, most significant digit first
    iter_t chain [MBITS+1];
    assign chain[0] = it_reg;

    for (genvar g = 0; g < MBITS; g++) begin : g_step
        tun_root_step u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .in_i    (chain[g]),
            .out_o   (chain[g+1])
        );
    end

    // rounding, saturation, sign, and zeroing of degenerate results
    logic                    m_tvalid_reg;
    logic [OUT_W-1:0]        norm_reg;
    logic [OUT_W-1:0]        norm_next;
    logic                    deg_reg;

    always_comb begin
        logic [MBITS:0]          inc;
        logic [MBITS-1:0]        q;
        logic [NORMAL_WIDTH-2:0] qm;
        logic [NORMAL_WIDTH-1:0] u;
        for (int i = 0; i < NLANE; i++) begin
            inc = {1'b0, chain[MBITS].lane[i].t} + (MBITS+1)'(1);
            q   = inc[MBITS:1];
            qm  = (q > MBITS'(MAG_MAX)) ? MAG_MAX : q[NORMAL_WIDTH-2:0];
            u   = {1'b0, qm};
            if (chain[MBITS].deg) begin
                u = '0;
            end else if (chain[MBITS].lane[i].neg) begin
                u = -u;
            end
            norm_next[i*NORMAL_WIDTH +: NORMAL_WIDTH] = u;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= chain[MBITS].valid;
        end
        if (en) begin
            norm_reg <= norm_next;
            deg_reg  <= chain[MBITS].deg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TW'(norm_reg);
    assign m_tuser  = deg_reg;

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import tun_pkg::*;

    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z
    logic [IN_TW-1:0]  s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // norm_x, norm_y, norm_z
    logic [OUT_TW-1:0] m_tdata;
    // degenerate
    logic              m_tuser;

    typedef struct {
        logic [NORMAL_WIDTH-1:0] nx;
        logic [NORMAL_WIDTH-1:0] ny;
        logic [NORMAL_WIDTH-1:0] nz;
        logic                    deg;
    } normal_t;

    // one normal component: sign(c) * round(|c| * 2^15 / |len|), saturated
    function automatic logic [NORMAL_WIDTH-1:0] unit_comp(longint c, logic [127:0] len2);
        logic [127:0] mag, rhs, lo, hi, mid, q;
        mag = (c < 0) ? 128'(-c) : 128'(c);
        rhs = ((2 * mag) * (2 * mag)) << (2 * (NORMAL_WIDTH - 1));
        lo = 0;
        hi = 128'd1 << NORMAL_WIDTH;
        // largest m with m^2 * len2 <= rhs, i.e. floor of twice the ratio
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid * len2 <= rhs) lo = mid;
            else hi = mid - 1;
        end
        q = (lo + 1) / 2;
        if (q > MAG_MAX) q = MAG_MAX;
        if (c < 0) q = -q;
        return q[NORMAL_WIDTH-1:0];
    endfunction

    function automatic normal_t face_normal(logic [IN_TW-1:0] d);
        longint  p[9];
        longint  ax, ay, az, bx, by, bz, cx, cy, cz;
        logic [127:0] mx, my, mz;
        logic [127:0] len2;
        normal_t n;
        for (int k = 0; k < 9; k++)
            p[k] = longint'($signed(d[k*COORD_WIDTH +: COORD_WIDTH]));
        ax = p[3] - p[0]; ay = p[4] - p[1]; az = p[5] - p[2];
        bx = p[6] - p[0]; by = p[7] - p[1]; bz = p[8] - p[2];
        cx = ay * bz - az * by;
        cy = az * bx - ax * bz;
        cz = ax * by - ay * bx;
        if (cx == 0 && cy == 0 && cz == 0) begin
            n = '{'0, '0, '0, 1'b1};
        end else begin
            // squares of the magnitudes exceed 64 bits, so work at 128
            mx = (cx < 0) ? 128'(-cx) : 128'(cx);
            my = (cy < 0) ? 128'(-cy) : 128'(cy);
            mz = (cz < 0) ? 128'(-cz) : 128'(cz);
            len2 = mx * mx + my * my + mz * mz;
            n.nx = unit_comp(cx, len2);
            n.ny = unit_comp(cy, len2);
            n.nz = unit_comp(cz, len2);
            n.deg = 1'b0;
        end
        return n;
    endfunction

    class normal_scoreboard;
        normal_t pending_normals[$];
        int      errors = 0;

        task report(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void note_triangle(logic [IN_TW-1:0] d);
            pending_normals = {pending_normals, face_normal(d)};
        endfunction

        task check_normal(logic [OUT_TW-1:0] d, logic deg);
            normal_t e;
            if (pending_normals.size() == 0) begin
                report("result with no triangle outstanding");
                return;
            end
            e = pending_normals.pop_front();
            if (d[0 +: NORMAL_WIDTH] !== e.nx)
                report($sformatf("norm_x got %0d exp %0d",
                    $signed(d[0 +: NORMAL_WIDTH]), $signed(e.nx)));
            if (d[NORMAL_WIDTH +: NORMAL_WIDTH] !== e.ny)
                report($sformatf("norm_y got %0d exp %0d",
                    $signed(d[NORMAL_WIDTH +: NORMAL_WIDTH]), $signed(e.ny)));
            if (d[2*NORMAL_WIDTH +: NORMAL_WIDTH] !== e.nz)
                report($sformatf("norm_z got %0d exp %0d",
                    $signed(d[2*NORMAL_WIDTH +: NORMAL_WIDTH]), $signed(e.nz)));
            if (deg !== e.deg)
                report($sformatf("degenerate got %b exp %b", deg, e.deg));
        endtask
    endclass

    normal_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;

    triangle_unit_normal u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // watch both channels
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_triangle(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_normal(m_tdata, m_tuser);
    end

    // receiver: random stalls plus a long hold-off on request
    always @(negedge aclk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_triangle(logic [IN_TW-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    function automatic logic [IN_TW-1:0] pack_corners(longint c[9]);
        logic [IN_TW-1:0] d;
        d = '0;
        for (int k = 0; k < 9; k++) d[k*COORD_WIDTH +: COORD_WIDTH] = COORD_WIDTH'(c[k]);
        return d;
    endfunction

    // random triangle of one of several shapes
    function automatic logic [IN_TW-1:0] random_triangle();
        longint c[9];
        longint s;
        int     kind;
        kind = $urandom_range(9);
        for (int k = 0; k < 9; k++) c[k] = $signed(16'($urandom));
        case (kind)
            0, 1, 2, 3: begin
                // full range corners
            end
            4, 5: begin
                // small triangle near corner 0
                for (int k = 3; k < 9; k++) c[k] = c[k-3] + $signed($urandom_range(8)) - 4;
            end
            6: begin
                // collinear: corner 2 on the line through corners 0 and 1
                s = $signed($urandom_range(6)) - 3;
                for (int k = 0; k < 3; k++) begin
                    c[k]   = $signed($urandom_range(2000)) - 1000;
                    c[k+3] = c[k] + $signed($urandom_range(200)) - 100;
                    c[k+6] = c[k] + s * (c[k+3] - c[k]);
                end
            end
            7: begin
                // triangle in an axis plane: one component at full scale
                s = $urandom_range(2);
                c[s] = 0; c[s+3] = 0; c[s+6] = 0;
            end
            8: begin
                // corners at the coordinate extremes
                for (int k = 0; k < 9; k++) c[k] = $urandom_range(1) ? 32767 : -32768;
            end
            default: begin
                // small integer coordinates
                for (int k = 0; k < 9; k++) c[k] = $signed($urandom_range(6)) - 3;
            end
        endcase
        return pack_corners(c);
    endfunction

    task automatic wait_drained();
        while (sb.pending_normals.size() != 0) @(negedge aclk);
    endtask

    initial begin
        longint lo_c[9], hi_c[9];
        sb = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // directed triangles
        send_triangle('0);
        send_triangle({9{16'h7FFF}});
        send_triangle({9{16'h8000}});
        send_triangle(pack_corners('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
        send_triangle(pack_corners('{0, 0, 0, 0, 1, 0, 1, 0, 0}));
        send_triangle(pack_corners('{0, 0, 0, 0, 1, 0, 0, 0, 1}));
        send_triangle(pack_corners('{0, 0, 0, 0, 0, 1, 0, 1, 0}));
        send_triangle(pack_corners('{0, 0, 0, 0, 0, 1, 1, 0, 0}));
        send_triangle(pack_corners('{0, 0, 0, 1, 0, 0, 0, 0, 1}));
        send_triangle(pack_corners('{-32768, -32768, -32768, 32767, -32768, -32768,
                                     -32768, 32767, -32768}));
        send_triangle(pack_corners('{-32768, -32768, -32768, 32767, 32767, -32768,
                                     -32768, 32767, 32767}));
        send_triangle(pack_corners('{32767, -32768, 32767, -32768, 32767, -32768,
                                     32767, 32767, -32768}));
        send_triangle(pack_corners('{0, 0, 0, 4, 0, 0, 0, 3, 0}));
        send_triangle(pack_corners('{0, 0, 0, 1, 1, 0, 0, 1, 1}));
        send_triangle(pack_corners('{0, 0, 0, 3, 4, 0, 0, 0, 5}));
        send_triangle(pack_corners('{1, 2, 3, 1, 2, 3, 7, 8, 9}));
        send_triangle(pack_corners('{1, 2, 3, 2, 4, 6, 3, 6, 9}));
        send_triangle(pack_corners('{5, 5, 5, 5, 5, 5, 5, 5, 5}));
        lo_c = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
        hi_c = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
        send_triangle(pack_corners(lo_c));
        send_triangle(pack_corners(hi_c));
        send_triangle(pack_corners('{1, 1, 1, 2, 1, 1, 1, 2, 1}));
        wait_drained();

        // random phases: none, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 52 : (ph == 3) ? 31 : 0;
            recv_stall_pct = (ph == 2) ? 52 : (ph == 3) ? 31 : 0;
            for (int i = 0; i < 145; i++) begin
                // long receiver hold-off to back the pipeline up
                if (ph == 0 && i == 40) hold_cycles = 150;
                send_triangle(random_triangle());
            end
            wait_drained();
        end

        repeat (40) @(negedge aclk);
        if (sb.errors == 0 && sb.pending_normals.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
